>>> hdl/assert_macros.svh
// Assertion macros used by the checker file of the rate tracker.
// Depends on nothing; the using scope must provide clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("counter_rate_tracker check failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
	`ASSERT_ALWAYS(label, (ante) |=> (cons))

`endif

>>> hdl/crt_pkg.sv
// Shared types and constants of the counter rate tracker.
// No dependencies; imported by the tracker, the divider and the checker.
`default_nettype none

package crt_pkg;

	localparam int SLOT_W  = 10;
	localparam int VALUE_W = 64;
	localparam int TIME_W  = 32;
	localparam int KIND_W  = 2;
	localparam int OUTC_W  = 3;

	// Stream beat layout
	localparam int IN_SLOT_LO   = 0;
	localparam int IN_VALUE_LO  = IN_SLOT_LO + SLOT_W;
	localparam int IN_TIME_LO   = IN_VALUE_LO + VALUE_W;
	localparam int IN_LIMIT_LO  = IN_TIME_LO + TIME_W;
	localparam int IN_TDATA_W   = 176;

	localparam int OUT_SLOT_LO  = 0;
	localparam int OUT_DELTA_LO = OUT_SLOT_LO + SLOT_W;
	localparam int OUT_RATE_LO  = OUT_DELTA_LO + VALUE_W;
	localparam int OUT_USED_W   = OUT_RATE_LO + VALUE_W;
	localparam int OUT_TDATA_W  = 144;
	localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_USED_W;

	// APB register file
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;
	localparam int REG_IDX_W = PADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_ALLOW_ZERO = 1'b0;

	// Divider: 64 quotient bits, one per cycle
	localparam int DIV_STEPS = 64;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [KIND_W-1:0] KIND_GAUGE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_C32   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_C64   = 2'd2;

	typedef enum logic [OUTC_W-1:0] {
		OUT_ACCEPT = 3'd0,
		OUT_FIRST  = 3'd1,
		OUT_OVER   = 3'd2,
		OUT_ZERO   = 3'd3,
		OUT_EQUAL  = 3'd4
	} outcome_t;

	typedef enum logic [3:0] {
		CRT_CLEAR,
		CRT_IDLE,
		CRT_REDUCE,
		CRT_READ,
		CRT_EVAL,
		CRT_FIX,
		CRT_DIVIDE,
		CRT_DECIDE,
		CRT_PUSH
	} crt_state_t;

	typedef struct packed {
		logic               valid;
		logic [VALUE_W-1:0] counter;
		logic [TIME_W-1:0]  stamp;
	} slot_entry_t;

endpackage

`default_nettype wire

>>> hdl/crt_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none

module crt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> hdl/crt_div.sv
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit a cycle.
// Depends on crt_pkg.
`default_nettype none

module crt_div import crt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [VALUE_W-1:0] dividend,
	input  logic [TIME_W-1:0]  divisor,
	output logic               done,
	output logic [VALUE_W-1:0] quotient
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [VALUE_W-1:0]   quo_q;
	logic [TIME_W-1:0]    rem_q;
	logic [TIME_W-1:0]    dvs_q;
	logic [TIME_W:0]      trial;
	logic [TIME_W:0]      diff;
	logic                 fits;

	// remainder stays below the divisor, so one extra bit covers the shift
	assign trial = {rem_q, quo_q[VALUE_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[VALUE_W-2:0], fits};
			rem_q <= fits ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

>>> hdl/counter_rate_tracker.sv
// Counter rate tracker: one sample in, one rate result out.
// Input beat: slot, value, time, speed limit in tdata; counter kind in tuser.
// Output beat: slot echo, wrap-corrected delta, rate in tdata; outcome in tuser.
// allow_zero sits at APB address 0; pready is tied high.
// Samples are handled one at a time. A counter sample goes from accept through
// slot read, evaluation and the 64-step bit-serial divider to its result; a gauge
// skips the divider, a first sample or an equal timestamp also skips the decide step.
// With SLOT_COUNT below 1024 a slot reduction is added ahead of the slot RAM read.
// After reset the slot RAM is swept clear, one entry a cycle; s_axis_tready
// stays low meanwhile, APB writes still land.
// Results go out through one output register. A stalled receiver holds the
// beat; the next sample is accepted and worked on, and waits only for the
// result slot to free.
// Depends on crt_pkg, crt_ram, crt_div.
`default_nettype none

module counter_rate_tracker import crt_pkg::*; #(
	parameter int SLOT_COUNT = 1024
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// slot_index, counter_value, sample_time, speed_limit, zero pad
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// counter_kind
	input  logic [KIND_W-1:0]      s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// slot_echo, counter_delta, rate_value, zero pad
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	// outcome
	output logic [OUTC_W-1:0]      m_axis_tuser,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [PADDR_W-1:0]     paddr,
	input  logic [PDATA_W-1:0]     pwdata,
	output logic [PDATA_W-1:0]     prdata,
	output logic                   pready
);

	localparam int ADDR_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int K_W    = $clog2(SLOT_W);
	localparam int RED_W  = $clog2(SLOT_COUNT + 1) + SLOT_W;
	localparam bit NEED_RED = SLOT_COUNT < (1 << SLOT_W);
	localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(SLOT_COUNT - 1);
	localparam logic [K_W-1:0]    K_TOP     = K_W'(SLOT_W - 1);
	localparam logic [RED_W-1:0]  SLOTS_R   = RED_W'(SLOT_COUNT);

	crt_state_t state_q, state_d;

	logic                   allow_zero_q;
	logic [ADDR_W-1:0]      clr_q;
	logic [SLOT_W-1:0]      slot_raw_q;
	logic [SLOT_W-1:0]      red_q;
	logic [K_W-1:0]         red_k_q;
	logic [VALUE_W-1:0]     cur_q;
	logic [TIME_W-1:0]      time_q;
	logic [KIND_W-1:0]      kind_q;
	logic [VALUE_W-1:0]     limit_q;
	logic                   first_q;
	logic [TIME_W-1:0]      elapsed_q;
	logic [VALUE_W-1:0]     diff_q;
	logic                   borrow_q;
	logic                   changed_q;
	logic [VALUE_W-1:0]     delta_q;
	logic [VALUE_W-1:0]     rate_q;
	outcome_t               outc_q;
	logic                   m_valid_q;
	logic [OUT_TDATA_W-1:0] m_data_q;
	outcome_t               m_user_q;

	logic                   ram_we;
	logic [ADDR_W-1:0]      ram_waddr;
	slot_entry_t            ram_wdata;
	slot_entry_t            ram_rdata;
	logic [ADDR_W-1:0]      slot_addr;
	logic [RED_W-1:0]       red_step;
	logic                   wrap_fix;
	logic [VALUE_W-1:0]     corr_delta;
	logic                   div_start;
	logic                   div_done;
	logic [VALUE_W-1:0]     div_quo;
	logic                   out_load;
	logic                   over_speed;
	logic                   nonzero;
	logic                   cfg_write;

	assign slot_addr = ADDR_W'(red_q);
	assign red_step  = SLOTS_R << red_k_q;

	// 32-bit counters (and the unused kind) that went down wrap at 2^32
	assign wrap_fix   = borrow_q && (kind_q != KIND_C64);
	assign corr_delta = {diff_q[VALUE_W-1:TIME_W] + TIME_W'(wrap_fix), diff_q[TIME_W-1:0]};

	assign over_speed = rate_q > limit_q;
	assign nonzero    = allow_zero_q
		|| ((kind_q != KIND_GAUGE) && (rate_q != '0))
		|| ((kind_q == KIND_GAUGE) && changed_q);

	crt_ram #(
		.WIDTH ($bits(slot_entry_t)),
		.DEPTH (SLOT_COUNT)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (slot_addr),
		.rdata (ram_rdata)
	);

	crt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (corr_delta),
		.divisor  (elapsed_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CRT_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = slot_addr;
		ram_wdata = '0;
		div_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			CRT_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				if (clr_q == LAST_SLOT) begin
					state_d = CRT_IDLE;
				end
			end
			CRT_IDLE: begin
				if (s_axis_tvalid) begin
					state_d = NEED_RED ? CRT_REDUCE : CRT_READ;
				end
			end
			CRT_REDUCE: begin
				if (red_k_q == '0) begin
					state_d = CRT_READ;
				end
			end
			CRT_READ: begin
				state_d = CRT_EVAL;
			end
			CRT_EVAL: begin
				// slot is overwritten whatever the outcome
				ram_we    = 1'b1;
				ram_wdata = slot_entry_t'{valid: 1'b1, counter: cur_q, stamp: time_q};
				state_d   = CRT_FIX;
			end
			CRT_FIX: begin
				if (first_q || (elapsed_q == '0)) begin
					state_d = CRT_PUSH;
				end else if (kind_q == KIND_GAUGE) begin
					state_d = CRT_DECIDE;
				end else begin
					div_start = 1'b1;
					state_d   = CRT_DIVIDE;
				end
			end
			CRT_DIVIDE: begin
				if (div_done) begin
					state_d = CRT_DECIDE;
				end
			end
			CRT_DECIDE: begin
				state_d = CRT_PUSH;
			end
			CRT_PUSH: begin
				if (!m_valid_q || m_axis_tready) begin
					out_load = 1'b1;
					state_d  = CRT_IDLE;
				end
			end
			default: begin
				state_d = CRT_IDLE;
			end
		endcase
	end

	assign s_axis_tready = (state_q == CRT_IDLE);

	// clear sweep pointer, output valid, register file
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q        <= '0;
			m_valid_q    <= 1'b0;
			allow_zero_q <= 1'b0;
		end else begin
			if (state_q == CRT_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			if (cfg_write && (paddr[PADDR_W-1:2] == REG_ALLOW_ZERO)) begin
				allow_zero_q <= pwdata[0];
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			CRT_IDLE: begin
				if (s_axis_tvalid) begin
					slot_raw_q <= s_axis_tdata[IN_SLOT_LO +: SLOT_W];
					red_q      <= s_axis_tdata[IN_SLOT_LO +: SLOT_W];
					red_k_q    <= K_TOP;
					cur_q      <= s_axis_tdata[IN_VALUE_LO +: VALUE_W];
					time_q     <= s_axis_tdata[IN_TIME_LO +: TIME_W];
					limit_q    <= s_axis_tdata[IN_LIMIT_LO +: VALUE_W];
					kind_q     <= s_axis_tuser;
				end
			end
			CRT_REDUCE: begin
				// slot modulo SLOT_COUNT, one shifted subtract a cycle
				if (RED_W'(red_q) >= red_step) begin
					red_q <= red_q - red_step[SLOT_W-1:0];
				end
				red_k_q <= red_k_q - 1'b1;
			end
			CRT_EVAL: begin
				first_q               <= !ram_rdata.valid;
				elapsed_q             <= time_q - ram_rdata.stamp;
				{borrow_q, diff_q}    <= {1'b0, cur_q} - {1'b0, ram_rdata.counter};
				changed_q             <= cur_q != ram_rdata.counter;
			end
			CRT_FIX: begin
				if (first_q) begin
					delta_q <= '0;
					rate_q  <= '0;
					outc_q  <= OUT_FIRST;
				end else if (elapsed_q == '0) begin
					delta_q <= '0;
					rate_q  <= '0;
					outc_q  <= OUT_EQUAL;
				end else if (kind_q == KIND_GAUGE) begin
					delta_q <= cur_q;
					rate_q  <= cur_q;
				end else begin
					delta_q <= corr_delta;
				end
			end
			CRT_DIVIDE: begin
				if (div_done) begin
					rate_q <= div_quo;
				end
			end
			CRT_DECIDE: begin
				if (over_speed) begin
					outc_q <= OUT_OVER;
				end else if (nonzero) begin
					outc_q <= OUT_ACCEPT;
				end else begin
					outc_q <= OUT_ZERO;
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			m_data_q <= {{OUT_PAD_W{1'b0}}, rate_q, delta_q, slot_raw_q};
			m_user_q <= outc_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

	assign pready = 1'b1;
	assign prdata = (paddr[PADDR_W-1:2] == REG_ALLOW_ZERO) ?
		{{(PDATA_W - 1){1'b0}}, allow_zero_q} : '0;

endmodule

`default_nettype wire

>>> hdl/crt_checker.sv
// Port-level checks of the counter rate tracker, bound to the top level.
// Depends on crt_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module crt_checker import crt_pkg::*; (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   s_axis_tvalid,
	input wire logic                   s_axis_tready,
	input wire logic                   m_axis_tvalid,
	input wire logic                   m_axis_tready,
	// slot_echo, counter_delta, rate_value, zero pad
	input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
	// outcome
	input wire logic [OUTC_W-1:0]      m_axis_tuser
);

	// a stalled result beat holds
	`ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

	// first sample and equal times carry no delta and no rate
	`ASSERT_ALWAYS(a_nodata_zero, m_axis_tvalid && (m_axis_tuser == OUT_FIRST || m_axis_tuser == OUT_EQUAL) |-> m_axis_tdata[OUT_USED_W-1:OUT_DELTA_LO] == '0)

	// dividing by a nonzero elapsed time never grows the delta
	`ASSERT_ALWAYS(a_rate_bound, m_axis_tvalid |-> m_axis_tdata[OUT_RATE_LO +: VALUE_W] <= m_axis_tdata[OUT_DELTA_LO +: VALUE_W])

	// one sample in flight: no accept on the cycle after an accept
	`ASSERT_NEXT(a_single_item, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

bind counter_rate_tracker crt_checker u_crt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

>>> tb/counter_rate_tracker_test.sv
`timescale 1ns / 100ps
// Self-checking bench for counter_rate_tracker: sample beats in, rate beats out,
// checked against an in-bench predictor of the per-slot rate logic.
// Depends on crt_pkg and counter_rate_tracker.

module counter_rate_tracker_test;
	import crt_pkg::*;

	localparam int SLOTS = 1024;
	localparam int POOL = 16;
	localparam int PHASES = 5;
	localparam int PHASE_BEATS = 246;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 100;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
	localparam logic [VALUE_W-1:0] ALL_ONES = '1;
	localparam logic [VALUE_W-1:0] WRAP_32 = 64'h1_0000_0000;

	typedef struct {
		logic [SLOT_W-1:0] slot;
		logic [VALUE_W-1:0] value;
		logic [TIME_W-1:0] stamp;
		logic [KIND_W-1:0] kind;
		logic [VALUE_W-1:0] limit;
	} sample_t;

	typedef struct {
		logic [SLOT_W-1:0] slot;
		logic [VALUE_W-1:0] delta;
		logic [VALUE_W-1:0] rate;
		logic [OUTC_W-1:0] outcome;
	} rate_result_t;

	class rate_scoreboard;
		bit allow_zero;
		bit seen[SLOTS];
		logic [VALUE_W-1:0] last_value[SLOTS];
		logic [TIME_W-1:0] last_stamp[SLOTS];
		rate_result_t expected_q[$];
		int errors;
		int checked;
		int tally[5];

		// Works out the rate beat for one accepted sample and updates the slot.
		function void note_sample(sample_t s);
			rate_result_t r;
			int idx;
			logic [TIME_W-1:0] elapsed;
			logic [VALUE_W-1:0] prev;
			idx = s.slot % SLOTS;
			r.slot = s.slot;
			r.delta = '0;
			r.rate = '0;
			if (!seen[idx]) begin
				r.outcome = OUT_FIRST;
			end else begin
				prev = last_value[idx];
				elapsed = s.stamp - last_stamp[idx];
				if (elapsed == 0) begin
					r.outcome = OUT_EQUAL;
				end else begin
					if (s.kind == KIND_GAUGE) begin
						r.delta = s.value;
						r.rate = s.value;
					end else begin
						r.delta = s.value - prev;
						// 64-bit counters wrap on their own; everything else by 2^32
						if (prev > s.value && s.kind != KIND_C64)
							r.delta += WRAP_32;
						r.rate = r.delta / {32'd0, elapsed};
					end
					if (r.rate > s.limit)
						r.outcome = OUT_OVER;
					else if (allow_zero || (s.kind != KIND_GAUGE && r.rate != 0) ||
							(s.kind == KIND_GAUGE && s.value != prev))
						r.outcome = OUT_ACCEPT;
					else
						r.outcome = OUT_ZERO;
				end
			end
			seen[idx] = 1'b1;
			last_value[idx] = s.value;
			last_stamp[idx] = s.stamp;
			expected_q.insert(expected_q.size(), r);
		endfunction

		function bit field_ok(string name, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
				return 1'b0;
			end
			return 1'b1;
		endfunction

		function void check_result(rate_result_t got);
			rate_result_t want;
			bit ok;
			if (expected_q.size() == 0) begin
				$display("%0t: result beat with none expected, actual slot %h outcome %h",
					$time, got.slot, got.outcome);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			ok = field_ok("slot_echo", 64'(want.slot), 64'(got.slot));
			ok &= field_ok("counter_delta", want.delta, got.delta);
			ok &= field_ok("rate_value", want.rate, got.rate);
			ok &= field_ok("outcome", 64'(want.outcome), 64'(got.outcome));
			if (!ok)
				errors++;
			checked++;
			tally[want.outcome]++;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata;
	logic [KIND_W-1:0] s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [OUTC_W-1:0] m_axis_tuser;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	rate_scoreboard sb = new();
	sample_t beat_in;
	rate_result_t beat_out;

	// stimulus-side view of what each slot last received
	logic [VALUE_W-1:0] sent_value[SLOTS];
	logic [TIME_W-1:0] sent_stamp[SLOTS];
	logic [SLOT_W-1:0] pool_slot[POOL];
	logic [KIND_W-1:0] pool_kind[POOL];

	int tx_idle_pct = 26;
	int rx_idle_pct = 26;
	int hold_req = 0;
	int hold_taken = 0;
	int hold_left = 0;
	int cycle_count = 0;

	counter_rate_tracker #(.SLOT_COUNT(SLOTS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results still expected", $time, sb.pending());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			beat_in.slot = s_axis_tdata[IN_SLOT_LO +: SLOT_W];
			beat_in.value = s_axis_tdata[IN_VALUE_LO +: VALUE_W];
			beat_in.stamp = s_axis_tdata[IN_TIME_LO +: TIME_W];
			beat_in.limit = s_axis_tdata[IN_LIMIT_LO +: VALUE_W];
			beat_in.kind = s_axis_tuser;
			sb.note_sample(beat_in);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			beat_out.slot = m_axis_tdata[OUT_SLOT_LO +: SLOT_W];
			beat_out.delta = m_axis_tdata[OUT_DELTA_LO +: VALUE_W];
			beat_out.rate = m_axis_tdata[OUT_RATE_LO +: VALUE_W];
			beat_out.outcome = m_axis_tuser;
			sb.check_result(beat_out);
		end
	end

	// Receiver: random stalls, plus a long hold-off when requested.
	always @(posedge clk) begin
		if (hold_req != hold_taken) begin
			hold_taken = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	function automatic sample_t mk(logic [SLOT_W-1:0] slot, logic [VALUE_W-1:0] value,
			logic [TIME_W-1:0] stamp, logic [KIND_W-1:0] kind, logic [VALUE_W-1:0] limit);
		sample_t s;
		s.slot = slot;
		s.value = value;
		s.stamp = stamp;
		s.kind = kind;
		s.limit = limit;
		return s;
	endfunction

	// Returns at the edge where the beat is taken; tvalid stays up for the caller.
	task automatic send_sample(sample_t s);
		logic [IN_TDATA_W-1:0] beat;
		beat = '0;
		beat[IN_SLOT_LO +: SLOT_W] = s.slot;
		beat[IN_VALUE_LO +: VALUE_W] = s.value;
		beat[IN_TIME_LO +: TIME_W] = s.stamp;
		beat[IN_LIMIT_LO +: VALUE_W] = s.limit;
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= beat;
		s_axis_tuser <= s.kind;
		sent_value[s.slot] = s.value;
		sent_stamp[s.slot] = s.stamp;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	// Write then read back allow_zero; call only with the block idle.
	task automatic write_allow_zero(bit v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_ALLOW_ZERO, 2'b00};
		pwdata <= PDATA_W'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		sb.allow_zero = v;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== PDATA_W'(v)) begin
			$display("%0t: allow_zero readback mismatch, expected %h, actual %h",
				$time, PDATA_W'(v), prdata);
			sb.errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	initial begin
		sample_t s;
		int p;
		int pick;
		logic [TIME_W-1:0] gap;
		logic [VALUE_W-1:0] step;

		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= '0;
		m_axis_tready <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		for (int i = 0; i < SLOTS; i++) begin
			sent_value[i] = {$urandom, $urandom};
			sent_stamp[i] = $urandom;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// gauges: first, unchanged, equal times, max value, over speed, over beats zero
		send_sample(mk(10'd5, 64'd100, 32'd1000, KIND_GAUGE, ALL_ONES));
		send_sample(mk(10'd5, 64'd100, 32'd1010, KIND_GAUGE, ALL_ONES));
		send_sample(mk(10'd5, 64'd200, 32'd1010, KIND_GAUGE, ALL_ONES));
		send_sample(mk(10'd5, ALL_ONES, 32'd1020, KIND_GAUGE, ALL_ONES));
		send_sample(mk(10'd5, 64'd300, 32'd1030, KIND_GAUGE, 64'd299));
		send_sample(mk(10'd5, 64'd300, 32'd1040, KIND_GAUGE, 64'd10));
		// 32-bit: counter and clock both wrap, then a zero rate, then the spare kind
		send_sample(mk(10'd1023, 64'hFFFF_FFF0, 32'hFFFF_FFF0, KIND_C32, ALL_ONES));
		send_sample(mk(10'd1023, 64'h10, 32'h10, KIND_C32, 64'd1));
		send_sample(mk(10'd1023, 64'h10, 32'h20, KIND_C32, ALL_ONES));
		send_sample(mk(10'd1023, 64'd5, 32'h30, KIND_SPARE, ALL_ONES));
		// 64-bit: modulo wrap over speed, clock going backwards, huge delta
		send_sample(mk(10'd0, ALL_ONES, 32'd7, KIND_C64, ALL_ONES));
		send_sample(mk(10'd0, 64'd0, 32'd8, KIND_C64, 64'd0));
		send_sample(mk(10'd0, 64'h123, 32'd7, KIND_C64, ALL_ONES));
		send_sample(mk(10'd0, 64'h8000_0000_0000_0122, 32'd8, KIND_C64, ALL_ONES));
		send_sample(mk(10'd512, 64'd0, 32'd0, KIND_C64, 64'd0));
		send_sample(mk(10'd512, ALL_ONES, 32'd1, KIND_C64, ALL_ONES));
		send_sample(mk(10'd512, 64'hFFFF_FFFF_0000_0000, 32'd3, KIND_C32, ALL_ONES));
		drain();
		write_allow_zero(1'b1);
		send_sample(mk(10'd5, 64'd300, 32'd1050, KIND_GAUGE, ALL_ONES));
		send_sample(mk(10'd1023, 64'd5, 32'h40, KIND_C32, ALL_ONES));
		send_sample(mk(10'd1023, 64'd5, 32'h40, KIND_C32, ALL_ONES));

		for (int phase = 0; phase < PHASES; phase++) begin
			drain();
			write_allow_zero(1'(phase % 2));
			tx_idle_pct = (phase == 3) ? 0 : 26;
			rx_idle_pct = (phase == 3) ? 0 : 26;
			for (int i = 0; i < POOL; i++) begin
				pool_slot[i] = SLOT_W'($urandom_range(SLOTS - 1));
				pool_kind[i] = KIND_W'($urandom_range(3));
			end
			for (int n = 0; n < PHASE_BEATS; n++) begin
				if (phase == 2 && n == 40)
					hold_req++;
				if ($urandom_range(99) < 20) begin
					// noise: any field value at all
					s = mk(SLOT_W'($urandom_range(SLOTS - 1)), {$urandom, $urandom}, $urandom,
						KIND_W'($urandom_range(3)), {$urandom, $urandom});
				end else begin
					p = $urandom_range(POOL - 1);
					s.slot = pool_slot[p];
					s.kind = ($urandom_range(19) == 0) ? KIND_W'($urandom_range(3)) :
						pool_kind[p];
					pick = $urandom_range(99);
					if (pick < 5)
						gap = '0;
					else if (pick < 8)
						gap = $urandom;
					else
						gap = $urandom_range(600, 1);
					s.stamp = sent_stamp[s.slot] + gap;
					if (s.kind == KIND_GAUGE) begin
						s.value = ($urandom_range(4) == 0) ? sent_value[s.slot] :
							64'($urandom_range(100000));
					end else begin
						pick = $urandom_range(99);
						if (pick < 10)
							step = '0;
						else if (pick < 15)
							step = {$urandom, $urandom};
						else
							step = 64'($urandom_range(5000)) * 64'(gap);
						s.value = sent_value[s.slot] + step;
						// 32-bit counters live below 2^32 in well-formed traffic
						if (s.kind != KIND_C64)
							s.value[VALUE_W-1:32] = '0;
					end
					pick = $urandom_range(99);
					if (pick < 35)
						s.limit = ALL_ONES;
					else if (pick < 75)
						s.limit = 64'($urandom_range(6000));
					else
						s.limit = {$urandom, $urandom};
				end
				send_sample(s);
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Checked %0d rate beats: %0d accepted, %0d first, %0d over speed, %0d zero, %0d equal times",
			sb.checked, sb.tally[OUT_ACCEPT], sb.tally[OUT_FIRST], sb.tally[OUT_OVER],
			sb.tally[OUT_ZERO], sb.tally[OUT_EQUAL]);
		$display("allow_zero run at 0 and 1, one %0d-cycle receiver hold, one stretch without gaps",
			HOLD_CYCLES);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
